// ----- design/rrts_pkg.sv -----
// Shared types and constants for the round-robin task scheduler.
// No dependencies.
`default_nettype none

package rrts_pkg;

    localparam int IDX_W = 8;   // wide enough for any table size in range

    // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> 35
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    typedef enum logic [2:0] {
        ST_UNUSED   = 3'd0,
        ST_READY    = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_SLEEPING = 3'd3,
        ST_ZOMBIE   = 3'd4
    } slot_st_t;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_YIELD  = 3'd1,
        OP_SLEEP  = 3'd2,
        OP_EXIT   = 3'd3,
        OP_CREATE = 3'd4,
        OP_KILL   = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        RES_OK       = 2'd0,
        RES_NO_SLOT  = 2'd1,
        RES_NO_ID    = 2'd2,
        RES_REFUSED  = 2'd3
    } res_t;

    typedef enum logic [1:0] {
        MODE_SCHED  = 2'd0,
        MODE_CREATE = 2'd1,
        MODE_KILL   = 2'd2
    } scan_mode_t;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_WAKE   = 3'd1,
        CMD_STATUS = 3'd2,
        CMD_SLEEP  = 3'd3,
        CMD_CREATE = 3'd4,
        CMD_LOAD   = 3'd5,
        CMD_SHIFT  = 3'd6,
        CMD_SWITCH = 3'd7
    } cmd_op_t;

    localparam int CFG_ENABLE = 0;
    localparam int CFG_IDLE   = 1;

    // Broadcast from the controller to every cell
    typedef struct packed {
        cmd_op_t            op;
        logic [IDX_W-1:0]   idx;       // target slot / new running slot
        logic [IDX_W-1:0]   alt_idx;   // old running slot on a switch
        slot_st_t           st;
        logic [31:0]        id;        // new id on create, target during kill scan
        logic [63:0]        wake;      // wake tick, or current tick for a wake pass
        scan_mode_t         mode;
        logic               idle_valid;
        logic [IDX_W-1:0]   idle_sel;
    } cell_cmd_t;

    // Per-cell report, already masked so the top level can OR them together
    typedef struct packed {
        logic        hit;
        logic [2:0]  run_status;
        logic [2:0]  idle_status;
        logic [31:0] run_id;
    } cell_stat_t;

endpackage

`default_nettype wire

// ----- design/round_robin_task_scheduler.sv -----
// Steps: spare opcodes and events with the scheduler off go straight to the result;
// create/kill load and run the token scan; tick/yield/exit pass wake, load, scan and
// switch, sleep first divides by ten; kill of the running task, once found, goes on as exit.
// Throughput: one word at a time, the next taken the cycle after its result is loaded;
// the token scan runs one slot per cycle. A stalled result holds the next.
// Reset: synchronous active-low aresetn; slot 0 running, slot 1 idle ready. Uses rrts_pkg.
`default_nettype none

module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [31:0] s_sleep_ms,
    input  wire logic [31:0] s_target_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [3:0]       m_new_slot,
    output logic [31:0]      m_new_task_id,
    output logic             m_switched,
    output logic [3:0]       m_running_slot,
    output logic [31:0]      m_running_task_id,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data
);

    cell_cmd_t  cmd;
    cell_stat_t stat [SLOTS];
    cell_stat_t chain_stat;
    logic       tok [SLOTS];

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        rrts_cell #(.INDEX(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .tok_in  (tok[(g == 0) ? SLOTS - 1 : g - 1]),
            .tok_out (tok[g]),
            .stat    (stat[g])
        );
    end

    always_comb begin
        chain_stat = '0;
        for (int i = 0; i < SLOTS; i++)
            chain_stat = chain_stat | stat[i];
    end

    rrts_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_sleep_ms        (s_sleep_ms),
        .s_target_id       (s_target_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_new_slot        (m_new_slot),
        .m_new_task_id     (m_new_task_id),
        .m_switched        (m_switched),
        .m_running_slot    (m_running_slot),
        .m_running_task_id (m_running_task_id),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .chain_stat        (chain_stat)
    );

endmodule

`default_nettype wire

// ----- design/rrts_cell.sv -----
// One task slot of the scheduler chain: status, id, wake tick, slice count
// and a scan token passed on to the next cell. Depends on rrts_pkg.
`default_nettype none

module rrts_cell
    import rrts_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_cmd_t  cmd,
    input  wire logic       tok_in,
    output logic            tok_out,
    output cell_stat_t      stat
);

    localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

    slot_st_t    status_reg, status_next;
    logic [31:0] id_reg,     id_next;
    logic [63:0] wake_reg,   wake_next;
    logic [31:0] slice_reg,  slice_next;
    logic        run_reg,    run_next;
    logic        tok_reg,    tok_next;

    logic me, is_idle, match;
    slot_st_t woken;

    always_comb begin
        me      = (cmd.idx == IDX);
        is_idle = cmd.idle_valid && (cmd.idle_sel == IDX);
        case (cmd.mode)
            MODE_SCHED:  match = (status_reg == ST_READY) && !is_idle;
            MODE_CREATE: match = (status_reg == ST_UNUSED);
            MODE_KILL:   match = (status_reg != ST_UNUSED) && (id_reg == cmd.id);
            default:     match = 1'b0;
        endcase

        woken = status_reg;
        if (status_reg == ST_SLEEPING && cmd.wake >= wake_reg)
            woken = ST_READY;
        if (woken == ST_ZOMBIE && !run_reg)
            woken = ST_UNUSED;

        status_next = status_reg;
        id_next     = id_reg;
        wake_next   = wake_reg;
        slice_next  = slice_reg;
        run_next    = run_reg;
        tok_next    = tok_reg;

        case (cmd.op)
            CMD_WAKE: status_next = woken;
            CMD_STATUS: begin
                if (me) status_next = cmd.st;
            end
            CMD_SLEEP: begin
                if (me) begin
                    status_next = ST_SLEEPING;
                    wake_next   = cmd.wake;
                end
            end
            CMD_CREATE: begin
                if (me) begin
                    status_next = ST_READY;
                    id_next     = cmd.id;
                    wake_next   = '0;
                    slice_next  = '0;
                end
            end
            CMD_LOAD:  tok_next = me;
            CMD_SHIFT: tok_next = tok_in;
            CMD_SWITCH: begin
                if (cmd.idx == cmd.alt_idx) begin
                    if (me && status_reg == ST_READY) status_next = ST_RUNNING;
                end else begin
                    if (cmd.alt_idx == IDX && status_reg == ST_RUNNING)
                        status_next = ST_READY;
                    if (me) begin
                        status_next = ST_RUNNING;
                        slice_next  = slice_reg + 32'd1;
                    end
                    run_next = me;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= (INDEX == 0) ? ST_RUNNING : ((INDEX == 1) ? ST_READY : ST_UNUSED);
            id_reg     <= (INDEX == 1) ? 32'd1 : 32'd0;
            wake_reg   <= '0;
            slice_reg  <= '0;
            run_reg    <= (INDEX == 0);
            tok_reg    <= 1'b0;
        end else begin
            status_reg <= status_next;
            id_reg     <= id_next;
            wake_reg   <= wake_next;
            slice_reg  <= slice_next;
            run_reg    <= run_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out          = tok_reg;
    assign stat.hit         = tok_reg & match;
    assign stat.run_status  = run_reg ? status_reg : 3'd0;
    assign stat.idle_status = is_idle ? status_reg : 3'd0;
    assign stat.run_id      = run_reg ? id_reg : 32'd0;

endmodule

`default_nettype wire

// ----- design/rrts_ctrl.sv -----
// Event sequencer: decodes each word, drives the cell chain through wake,
// token scan and switch steps, and holds the result register. Uses rrts_pkg.
`default_nettype none

module rrts_ctrl
    import rrts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [31:0] s_sleep_ms,
    input  wire logic [31:0] s_target_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [3:0]       m_new_slot,
    output logic [31:0]      m_new_task_id,
    output logic             m_switched,
    output logic [3:0]       m_running_slot,
    output logic [31:0]      m_running_task_id,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data,
    output cell_cmd_t        cmd,
    input  wire cell_stat_t  chain_stat
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIV    = 8'b0000_0010,
        S_QUO    = 8'b0000_0100,
        S_WAKE   = 8'b0000_1000,
        S_LOAD   = 8'b0001_0000,
        S_SCAN   = 8'b0010_0000,
        S_SWITCH = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    scan_mode_t  mode_reg, mode_next;
    logic        enable_reg, enable_next;
    logic [3:0]  idle_reg, idle_next;
    logic [63:0] tick_reg, tick_next;
    logic [31:0] next_id_reg, next_id_next;
    logic [IW-1:0] run_reg, run_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] choice_reg, choice_next;
    logic [31:0] ms_reg, ms_next;
    logic [31:0] target_reg, target_next;
    logic [63:0] prod_reg, prod_next;
    res_t        res_reg, res_next;
    logic [IW-1:0] new_slot_reg, new_slot_next;
    logic [31:0] new_id_reg, new_id_next;
    logic        sw_reg, sw_next;
    logic        mv_reg, mv_next;
    logic [1:0]  mstat_reg, mstat_next;
    logic [3:0]  mslot_reg, mslot_next;
    logic [31:0] mid_reg, mid_next;
    logic        msw_reg, msw_next;
    logic [3:0]  mrun_reg, mrun_next;
    logic [31:0] mrid_reg, mrid_next;

    logic          idle_in;
    logic [IW-1:0] idle_pos;
    logic [28:0]   quo;
    logic [32:0]   quo10;
    logic          rem_nz;
    logic [IW-1:0] run_succ;

    assign idle_in   = 32'(idle_reg) < 32'(SLOTS);
    assign idle_pos  = IW'(idle_reg);
    assign quo       = prod_reg[63:RECIP10_SHIFT];
    assign quo10     = {1'b0, quo, 3'b000} + {3'b000, quo, 1'b0};
    assign rem_nz    = (quo10[31:0] != ms_reg);
    assign run_succ  = (run_reg == LAST) ? '0 : run_reg + 1'b1;
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        enable_next   = enable_reg;
        idle_next     = idle_reg;
        tick_next     = tick_reg;
        next_id_next  = next_id_reg;
        run_next      = run_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        choice_next   = choice_reg;
        ms_next       = ms_reg;
        target_next   = target_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        new_slot_next = new_slot_reg;
        new_id_next   = new_id_reg;
        sw_next       = sw_reg;
        mv_next       = mv_reg;
        mstat_next    = mstat_reg;
        mslot_next    = mslot_reg;
        mid_next      = mid_reg;
        msw_next      = msw_reg;
        mrun_next     = mrun_reg;
        mrid_next     = mrid_reg;

        cmd.op         = CMD_NONE;
        cmd.idx        = IDX_W'(run_reg);
        cmd.alt_idx    = IDX_W'(run_reg);
        cmd.st         = ST_ZOMBIE;
        cmd.id         = (mode_reg == MODE_KILL) ? target_reg : next_id_reg;
        cmd.wake       = tick_reg;
        cmd.mode       = mode_reg;
        cmd.idle_valid = idle_in;
        cmd.idle_sel   = IDX_W'(idle_reg);

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == 1'(CFG_ENABLE)) enable_next = cfg_data[0];
            else                             idle_next   = cfg_data;
        end

        if (mv_reg && m_ready) mv_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ms_next       = s_sleep_ms;
                    target_next   = s_target_id;
                    res_next      = RES_OK;
                    new_slot_next = '0;
                    new_id_next   = '0;
                    sw_next       = 1'b0;
                    mode_next     = MODE_SCHED;
                    case (s_opcode)
                        OP_TICK: begin
                            tick_next  = tick_reg + 64'd1;
                            state_next = enable_reg ? S_WAKE : S_RESULT;
                        end
                        OP_YIELD: state_next = enable_reg ? S_WAKE : S_RESULT;
                        OP_SLEEP: state_next = enable_reg ? S_DIV : S_RESULT;
                        OP_EXIT: begin
                            cmd.op     = CMD_STATUS;
                            cmd.st     = ST_ZOMBIE;
                            state_next = enable_reg ? S_WAKE : S_RESULT;
                        end
                        OP_CREATE, OP_KILL: begin
                            mode_next  = (s_opcode == OP_CREATE) ? MODE_CREATE : MODE_KILL;
                            cmd.op     = CMD_LOAD;
                            cmd.idx    = '0;
                            pos_next   = '0;
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        default: state_next = S_RESULT;
                    endcase
                end
            end
            S_DIV: begin
                prod_next  = ms_reg * RECIP10;
                state_next = S_QUO;
            end
            S_QUO: begin
                // ceil(ms/10) = floor + (remainder != 0)
                cmd.op     = CMD_SLEEP;
                cmd.wake   = tick_reg + 64'(quo) + 64'(rem_nz);
                state_next = S_WAKE;
            end
            S_WAKE: begin
                cmd.op     = CMD_WAKE;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.op     = CMD_LOAD;
                cmd.idx    = IDX_W'(run_succ);
                pos_next   = run_succ;
                cnt_next   = '0;
                mode_next  = MODE_SCHED;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (chain_stat.hit) begin
                    case (mode_reg)
                        MODE_SCHED: begin
                            choice_next = pos_reg;
                            state_next  = S_SWITCH;
                        end
                        MODE_CREATE: begin
                            cmd.op        = CMD_CREATE;
                            cmd.idx       = IDX_W'(pos_reg);
                            new_slot_next = pos_reg;
                            new_id_next   = next_id_reg;
                            next_id_next  = next_id_reg + 32'd1;
                            state_next    = S_RESULT;
                        end
                        default: begin
                            if (pos_reg == '0 || (idle_in && pos_reg == idle_pos)) begin
                                res_next   = RES_REFUSED;
                                state_next = S_RESULT;
                            end else if (pos_reg == run_reg) begin
                                // same as exit of the running task
                                cmd.op     = CMD_STATUS;
                                cmd.st     = ST_ZOMBIE;
                                mode_next  = MODE_SCHED;
                                state_next = enable_reg ? S_WAKE : S_RESULT;
                            end else begin
                                cmd.op     = CMD_STATUS;
                                cmd.idx    = IDX_W'(pos_reg);
                                cmd.st     = ST_UNUSED;
                                state_next = S_RESULT;
                            end
                        end
                    endcase
                end else if (cnt_reg == LAST) begin
                    case (mode_reg)
                        MODE_SCHED: begin
                            if (chain_stat.run_status == ST_RUNNING)
                                choice_next = run_reg;
                            else if (chain_stat.idle_status != ST_UNUSED)
                                choice_next = idle_pos;   // only reports when in table
                            else
                                choice_next = run_reg;
                            state_next = S_SWITCH;
                        end
                        MODE_CREATE: begin
                            res_next   = RES_NO_SLOT;
                            state_next = S_RESULT;
                        end
                        default: begin
                            res_next   = RES_NO_ID;
                            state_next = S_RESULT;
                        end
                    endcase
                end else begin
                    cmd.op   = CMD_SHIFT;
                    pos_next = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SWITCH: begin
                cmd.op      = CMD_SWITCH;
                cmd.idx     = IDX_W'(choice_reg);
                cmd.alt_idx = IDX_W'(run_reg);
                sw_next     = (choice_reg != run_reg);
                run_next    = choice_reg;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mstat_next = res_reg;
                    mslot_next = 4'(new_slot_reg);
                    mid_next   = new_id_reg;
                    msw_next   = sw_reg;
                    mrun_next  = 4'(run_reg);
                    mrid_next  = chain_stat.run_id;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_SCHED;
            enable_reg  <= 1'b1;
            idle_reg    <= 4'd1;
            tick_reg    <= '0;
            next_id_reg <= 32'd2;
            run_reg     <= '0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            enable_reg  <= enable_next;
            idle_reg    <= idle_next;
            tick_reg    <= tick_next;
            next_id_reg <= next_id_next;
            run_reg     <= run_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        choice_reg   <= choice_next;
        ms_reg       <= ms_next;
        target_reg   <= target_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        new_slot_reg <= new_slot_next;
        new_id_reg   <= new_id_next;
        sw_reg       <= sw_next;
        mstat_reg    <= mstat_next;
        mslot_reg    <= mslot_next;
        mid_reg      <= mid_next;
        msw_reg      <= msw_next;
        mrun_reg     <= mrun_next;
        mrid_reg     <= mrid_next;
    end

    assign m_valid           = mv_reg;
    assign m_status          = mstat_reg;
    assign m_new_slot        = mslot_reg;
    assign m_new_task_id     = mid_reg;
    assign m_switched        = msw_reg;
    assign m_running_slot    = mrun_reg;
    assign m_running_task_id = mrid_reg;

endmodule

`default_nettype wire

// ----- design/rrts_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
// Depends on round_robin_task_scheduler's ports only.
`default_nettype none

module rrts_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [3:0]  m_new_slot,
    input wire logic [31:0] m_new_task_id,
    input wire logic        m_switched,
    input wire logic [3:0]  m_running_slot
);

    // held result word keeps its running slot
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_running_slot))
        else $error("result word changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // failed create, missing or refused kill never carry a new task
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != 2'd0 |-> m_new_slot == 4'd0 && m_new_task_id == 32'd0)
        else $error("failed event reports a new task");

    a_fail_noswitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != 2'd0 |-> !m_switched)
        else $error("failed event switched task");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_new_slot    (m_new_slot),
    .m_new_task_id (m_new_task_id),
    .m_switched    (m_switched),
    .m_running_slot(m_running_slot)
);

`default_nettype wire
